### src/euler_totient_unit_defines.svh
// assertion macros for the euler totient unit
// no dependencies; included by files that carry concurrent assertions
`ifndef EULER_TOTIENT_UNIT_DEFINES_SVH
`define EULER_TOTIENT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ETU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("etu assertion failed");

// next-cycle implication, checked out of reset
`define ETU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("etu assertion failed");

`else

`define ETU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ETU_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### src/etu_pkg.sv
// shared types for the euler totient unit
// no dependencies; used by etu_div and euler_totient_unit
`default_nettype none

package etu_pkg;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } etu_div_stat_t;

endpackage

`default_nettype wire

### src/etu_div.sv
// restoring divider, one quotient bit per cycle, done after the last quotient bit
// depends on etu_pkg for the status struct
`default_nettype none

module etu_div #(
    parameter int WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [WIDTH-1:0]      dividend,
    input  wire logic [WIDTH-1:0]      divisor,
    output logic      [WIDTH-1:0]      quotient,
    output logic      [WIDTH-1:0]      remainder,
    output etu_pkg::etu_div_stat_t     stat
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // shift in next dividend bit and try subtracting
    assign rem_sh = {rem_reg, quo_reg[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
            rem_next = diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### src/euler_totient_unit.sv
// euler totient unit top level: sequencer around one shared divider
// depends on etu_pkg, etu_div and euler_totient_unit_defines.svh
`default_nettype none

// Computes phi(n) for one unsigned n per item by trial division with a running
// product: starting from acc = n, every distinct prime p found in n replaces acc by
// acc - acc/p (exact, equal to acc/p*(p-1)); a cofactor above one left after the
// search is a prime and is handled the same way. phi(0) is returned as 0, phi(1)
// as 1. All divisions go through one restoring divider, so the time an item takes
// grows with the number of divides issued: one divide per candidate tried, plus
// two for each prime factor found in the search, one per repeated factor and one
// for a leftover prime. The worst case is a large prime, about 2^(N_WIDTH/2)
// candidates. The input side is ready only while the sequencer is idle; the
// result sits in an output register, so a new item is taken while a finished
// one waits downstream.
module euler_totient_unit #(
    parameter int N_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // number_in in the low N_WIDTH bits, zero padding above
    input  wire logic [((N_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // totient_out in the low N_WIDTH bits, zero padding above
    output logic      [((N_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

`include "euler_totient_unit_defines.svh"

    localparam int DW = ((N_WIDTH + 7) / 8) * 8;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for an item
        ST_TEST  = 6'b000010,   // rest / x: bound check and divisibility
        ST_ACCD  = 6'b000100,   // acc / x for the running product
        ST_STRIP = 6'b001000,   // strip further powers of x from rest
        ST_FINAL = 6'b010000,   // acc / rest for a leftover prime
        ST_DONE  = 6'b100000    // result ready, waiting for output register
    } state_t;

    state_t               state_reg, state_next;
    logic [N_WIDTH-1:0]   rest_reg, rest_next;
    logic [N_WIDTH-1:0]   acc_reg, acc_next;
    logic [N_WIDTH-1:0]   x_reg, x_next;
    logic                 go_reg, go_next;
    logic                 ovalid_reg, ovalid_next;
    logic [N_WIDTH-1:0]   odata_reg, odata_next;

    logic [N_WIDTH-1:0]   div_a;
    logic [N_WIDTH-1:0]   div_b;
    logic [N_WIDTH-1:0]   div_q;
    logic [N_WIDTH-1:0]   div_r;
    etu_pkg::etu_div_stat_t div_stat;

    logic                 in_acc;
    logic [N_WIDTH-1:0]   n_in;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign n_in   = s_axis_tdata[N_WIDTH-1:0];

    // operand select: acc is divided in the product steps, rest otherwise
    always_comb
    begin
        div_a = rest_reg;
        div_b = x_reg;
        if (state_reg == ST_ACCD)
        begin
            div_a = acc_reg;
        end
        else if (state_reg == ST_FINAL)
        begin
            div_a = acc_reg;
            div_b = rest_reg;
        end
    end

    etu_div #(
        .WIDTH (N_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (go_reg),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        rest_next   = rest_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        go_next     = 1'b0;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        // output register drains independently of the sequencer
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rest_next = n_in;
                    acc_next  = n_in;
                    x_next    = N_WIDTH'(2);
                    if (n_in == '0)
                    begin
                        // zero input gives zero
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST:
            begin
                if (div_stat.done)
                begin
                    if (x_reg <= div_q)
                    begin
                        if (div_r == '0)
                        begin
                            // x is a prime factor; one power already stripped
                            rest_next  = div_q;
                            go_next    = 1'b1;
                            state_next = ST_ACCD;
                        end
                        else
                        begin
                            x_next     = x_reg + N_WIDTH'(1);
                            go_next    = 1'b1;
                            state_next = ST_TEST;
                        end
                    end
                    else if (rest_reg > N_WIDTH'(1))
                    begin
                        go_next    = 1'b1;
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACCD:
            begin
                if (div_stat.done)
                begin
                    acc_next   = acc_reg - div_q;
                    go_next    = 1'b1;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (div_stat.done)
                begin
                    go_next = 1'b1;
                    if (div_r == '0)
                    begin
                        rest_next  = div_q;
                        state_next = ST_STRIP;
                    end
                    else
                    begin
                        x_next     = x_reg + N_WIDTH'(1);
                        state_next = ST_TEST;
                    end
                end
            end
            ST_FINAL:
            begin
                if (div_stat.done)
                begin
                    acc_next   = acc_reg - div_q;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    odata_next  = acc_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            go_reg     <= go_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg  <= rest_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        odata_reg <= odata_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = DW'(odata_reg);

    // an accepted item makes the block busy on the next cycle
    `ETU_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, !s_axis_tready)
    // a divide is never launched on top of one still running
    `ETU_ASSERT_IMPL(a_div_free, clk, rst_n, go_reg, !div_stat.busy)
    // the trial divisor never drops below two while searching
    `ETU_ASSERT_IMPL(a_x_min, clk, rst_n,
        (state_reg == ST_TEST) || (state_reg == ST_STRIP), x_reg >= N_WIDTH'(2))
    // the running product stays nonzero while factoring
    `ETU_ASSERT_IMPL(a_acc_nz, clk, rst_n,
        (state_reg == ST_ACCD) || (state_reg == ST_FINAL), acc_reg != '0)

endmodule

`default_nettype wire
